### rtl/wsfd_pkg.sv
// Package for the WebSocket frame deframer.
// Holds the parse phase type, the result word type and the opcode constants.
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASKKEY = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic       is_payload;
    logic [3:0] frame_opcode;
    logic       fin_bit;
    logic       frame_end;
    logic       deliver_binary;
    logic       close_request;
  } result_t;

endpackage

### rtl/wsfd_parse.sv
// Frame header parser and payload unmasker for the WebSocket frame deframer.
// Holds the per-frame state; depends on wsfd_pkg.
module wsfd_parse #(
  parameter int LENGTH_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output wsfd_pkg::result_t res
);
  import wsfd_pkg::*;

  phase_t                 phase, phase_next;
  logic [3:0]             cur_opcode, cur_opcode_next;
  logic                   cur_fin, cur_fin_next;
  logic                   cur_masked, cur_masked_next;
  logic [3:0]             header_byte_count, header_byte_count_next;
  logic [LENGTH_BITS-1:0] remaining_length, remaining_length_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [1:0]             mask_index, mask_index_next;

  logic                   len_ready;
  logic [LENGTH_BITS-1:0] len_new;
  logic [LENGTH_BITS-1:0] ext_len;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [3:0]             count_dec;
  logic                   zero_end;
  logic [7:0]             key_byte;

  assign count_dec = header_byte_count - 4'd1;
  assign rem_dec   = remaining_length - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  assign ext_len   = (|remaining_length[LENGTH_BITS-1:LENGTH_BITS-8]) ? '1 :
                     {remaining_length[LENGTH_BITS-9:0], rx_byte};

  always_comb begin
    unique case (mask_index)
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      2'd3: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next             = phase;
    cur_opcode_next        = cur_opcode;
    cur_fin_next           = cur_fin;
    cur_masked_next        = cur_masked;
    header_byte_count_next = header_byte_count;
    remaining_length_next  = remaining_length;
    mask_key_next          = mask_key;
    mask_index_next        = mask_index;
    len_ready              = 1'b0;
    len_new                = '0;
    zero_end               = 1'b0;
    unique case (phase)
      PH_HDR1: begin
        cur_masked_next = rx_byte[7];
        if (rx_byte[6:0] == LEN7_EXT16 || rx_byte[6:0] == LEN7_EXT64) begin
          header_byte_count_next = (rx_byte[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          remaining_length_next  = '0;
          phase_next             = PH_EXTLEN;
        end else begin
          len_ready = 1'b1;
          len_new   = LENGTH_BITS'(rx_byte[6:0]);
        end
      end
      PH_EXTLEN: begin
        remaining_length_next  = ext_len;
        header_byte_count_next = count_dec;
        if (count_dec == 4'd0) begin
          len_ready = 1'b1;
          len_new   = ext_len;
        end
      end
      PH_MASKKEY: begin
        mask_key_next          = {mask_key[23:0], rx_byte};
        header_byte_count_next = count_dec;
        if (count_dec == 4'd0) begin
          mask_index_next = 2'd0;
          if (remaining_length == '0) begin
            phase_next = PH_HDR0;
            zero_end   = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        mask_index_next       = mask_index + 2'd1;
        remaining_length_next = rem_dec;
        if (rem_dec == '0) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        cur_fin_next    = rx_byte[7];
        cur_opcode_next = rx_byte[3:0];
        phase_next      = PH_HDR1;
      end
    endcase
    if (len_ready) begin
      remaining_length_next = len_new;
      if (cur_masked_next) begin
        phase_next             = PH_MASKKEY;
        header_byte_count_next = KEY_BYTES;
        mask_key_next          = '0;
      end else begin
        mask_index_next = 2'd0;
        if (len_new == '0) begin
          phase_next = PH_HDR0;
          zero_end   = 1'b1;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
    end
  end

  always_comb begin
    res              = '0;
    res.frame_opcode = cur_opcode;
    res.fin_bit      = cur_fin;
    if (phase == PH_PAYLOAD) begin
      res.valid        = 1'b1;
      res.is_payload   = 1'b1;
      res.payload_byte = rx_byte ^ (cur_masked ? key_byte : 8'd0);
      res.frame_end    = (rem_dec == '0);
    end else if (zero_end) begin
      res.valid     = 1'b1;
      res.frame_end = 1'b1;
    end
    res.deliver_binary = res.frame_end && (cur_opcode == OP_BINARY);
    res.close_request  = res.frame_end && (cur_opcode == OP_CLOSE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR0;
      cur_opcode        <= '0;
      cur_fin           <= 1'b0;
      cur_masked        <= 1'b0;
      header_byte_count <= '0;
      remaining_length  <= '0;
      mask_key          <= '0;
      mask_index        <= '0;
    end else if (step) begin
      phase             <= phase_next;
      cur_opcode        <= cur_opcode_next;
      cur_fin           <= cur_fin_next;
      cur_masked        <= cur_masked_next;
      header_byte_count <= header_byte_count_next;
      remaining_length  <= remaining_length_next;
      mask_key          <= mask_key_next;
      mask_index        <= mask_index_next;
    end
  end

endmodule

### rtl/websocket_frame_deframer.sv
// WebSocket frame deframer, top level: input word register, parser, result register.
// Each accepted word is held in the input register until the result register can take its result.
// Throughput: one word per cycle; the parser state updates as each word leaves
// the input register, and a held result only stalls the input while it waits.
// Reset (synchronous, active high) empties both registers and returns the
// parser to expect the first header byte of a frame. Depends on wsfd_pkg.
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] payload_byte,
  output logic       is_payload,
  output logic [3:0] frame_opcode,
  output logic       fin_bit,
  output logic       frame_end,
  output logic       deliver_binary,
  output logic       close_request
);
  import wsfd_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  result_t    res;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  wsfd_parse #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .rx_byte(in_byte),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= advance && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      payload_byte   <= res.payload_byte;
      is_payload     <= res.is_payload;
      frame_opcode   <= res.frame_opcode;
      fin_bit        <= res.fin_bit;
      frame_end      <= res.frame_end;
      deliver_binary <= res.deliver_binary;
      close_request  <= res.close_request;
    end
  end

endmodule

### rtl/wsfd_checker.sv
// Port-level checks for the WebSocket frame deframer, bound to the top level.
// Depends on wsfd_pkg.
module wsfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] rx_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] payload_byte,
  input logic       is_payload,
  input logic [3:0] frame_opcode,
  input logic       fin_bit,
  input logic       frame_end,
  input logic       deliver_binary,
  input logic       close_request
);
  import wsfd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(frame_end))
    else $error("result word changed while stalled");

  a_end_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_payload |-> frame_end && payload_byte == 8'd0)
    else $error("non-payload word is not a clean end marker");

  a_binary_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && deliver_binary |-> frame_end && frame_opcode == OP_BINARY)
    else $error("binary delivery outside binary frame end");

  a_close_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && close_request |-> frame_end && frame_opcode == OP_CLOSE)
    else $error("close request outside close frame end");

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (.*);

### sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for websocket_frame_deframer: random and directed byte streams of framed
// WebSocket traffic, checked word by word against an in-bench frame parser.
// Depends on wsfd_pkg and the deframer RTL.
module testbench;
  import wsfd_pkg::*;

  localparam int LEN_W = 64;
  localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LEN_W);

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

  class deframer_scoreboard;
    phase_t      ph;
    logic [3:0]  opcode;
    logic        fin;
    logic        masked;
    logic [3:0]  hdr_cnt;
    logic [63:0] remaining;
    logic [31:0] key;
    logic [1:0]  key_idx;
    result_t     expected_q[$];
    int          fail_count;

    function new();
      ph = PH_HDR0;
      opcode = '0;
      fin = 1'b0;
      masked = 1'b0;
      hdr_cnt = '0;
      remaining = '0;
      key = '0;
      key_idx = '0;
      fail_count = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_result(logic [7:0] data, logic is_data, logic last);
      result_t r;
      r.valid = 1'b1;
      r.payload_byte = data;
      r.is_payload = is_data;
      r.frame_opcode = opcode;
      r.fin_bit = fin;
      r.frame_end = last;
      r.deliver_binary = last && (opcode == OP_BINARY);
      r.close_request = last && (opcode == OP_CLOSE);
      expected_q.push_back(r);
    endfunction

    function void start_payload();
      key_idx = '0;
      if (remaining == '0) begin
        ph = PH_HDR0;
        push_result(8'h00, 1'b0, 1'b1);
      end else begin
        ph = PH_PAYLOAD;
      end
    endfunction

    function void finish_length();
      if (masked) begin
        ph = PH_MASKKEY;
        hdr_cnt = KEY_BYTES;
        key = '0;
      end else begin
        start_payload();
      end
    endfunction

    function void note_word(logic [7:0] b);
      logic [6:0] len7;
      logic [7:0] kb;
      logic       last;
      case (ph)
        PH_HDR1: begin
          len7 = b[6:0];
          masked = b[7];
          if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
            hdr_cnt = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            remaining = '0;
            ph = PH_EXTLEN;
          end else begin
            remaining = 64'(len7);
            finish_length();
          end
        end
        PH_EXTLEN: begin
          if (remaining > (LEN_MAX >> 8)) remaining = LEN_MAX;
          else remaining = ((remaining << 8) | 64'(b)) & LEN_MAX;
          hdr_cnt = hdr_cnt - 4'd1;
          if (hdr_cnt == '0) finish_length();
        end
        PH_MASKKEY: begin
          key = {key[23:0], b};
          hdr_cnt = hdr_cnt - 4'd1;
          if (hdr_cnt == '0) start_payload();
        end
        PH_PAYLOAD: begin
          kb = masked ? 8'(key >> (8 * (3 - int'(key_idx)))) : 8'h00;
          key_idx = key_idx + 2'd1;
          remaining = (remaining - 64'd1) & LEN_MAX;
          last = (remaining == '0);
          if (last) ph = PH_HDR0;
          push_result(b ^ kb, 1'b1, last);
        end
        default: begin
          fin = b[7];
          opcode = b[3:0];
          ph = PH_HDR1;
        end
      endcase
    endfunction

    function string fmt(result_t r);
      return $sformatf("byte=%h data=%b op=%h fin=%b end=%b bin=%b close=%b",
                       r.payload_byte, r.is_payload, r.frame_opcode, r.fin_bit,
                       r.frame_end, r.deliver_binary, r.close_request);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected word: %s", fmt(got));
        return;
      end
      exp = expected_q.pop_front();
      if (got.payload_byte !== exp.payload_byte || got.is_payload !== exp.is_payload ||
          got.frame_opcode !== exp.frame_opcode || got.fin_bit !== exp.fin_bit ||
          got.frame_end !== exp.frame_end || got.deliver_binary !== exp.deliver_binary ||
          got.close_request !== exp.close_request) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch: expected %s, got %s", fmt(exp), fmt(got));
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] payload_byte;
  logic       is_payload;
  logic [3:0] frame_opcode;
  logic       fin_bit;
  logic       frame_end;
  logic       deliver_binary;
  logic       close_request;

  logic [15:0] stall_pat = 16'hFFFF;
  logic [5:0]  stall_age = '0;
  logic [7:0]  rx_stream[$];

  deframer_scoreboard sb = new();

  websocket_frame_deframer #(.LENGTH_BITS(LEN_W)) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .payload_byte(payload_byte),
    .is_payload(is_payload),
    .frame_opcode(frame_opcode),
    .fin_bit(fin_bit),
    .frame_end(frame_end),
    .deliver_binary(deliver_binary),
    .close_request(close_request)
  );

  always #2 clk = ~clk;

  // Rotate a stall pattern, replaced whenever the age counter wraps.
  always @(posedge clk) begin
    if (stall_age == '0) begin
      case ($urandom_range(0, 3))
        0: stall_pat <= 16'hFFFF;
        1: stall_pat <= 16'($urandom);
        2: stall_pat <= 16'($urandom | $urandom);
        default: stall_pat <= 16'($urandom & $urandom);
      endcase
    end else begin
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
    end
    stall_age <= stall_age + 6'd1;
    out_ready <= stall_pat[15];
  end

  always @(posedge clk) begin
    result_t seen;
    seen.valid = 1'b1;
    seen.payload_byte = payload_byte;
    seen.is_payload = is_payload;
    seen.frame_opcode = frame_opcode;
    seen.fin_bit = fin_bit;
    seen.frame_end = frame_end;
    seen.deliver_binary = deliver_binary;
    seen.close_request = close_request;
    if (!rst && in_valid && in_ready) sb.note_word(rx_byte);
    if (!rst && out_valid && out_ready) sb.check_result(seen);
  end

  task automatic push_frame(input logic [7:0] hdr0, input logic masked, input len_form_t form,
                            input logic [63:0] length, input logic [31:0] key,
                            input int n_payload);
    rx_stream.push_back(hdr0);
    case (form)
      LEN_SHORT: rx_stream.push_back({masked, length[6:0]});
      LEN_EXT16: begin
        rx_stream.push_back({masked, LEN7_EXT16});
        rx_stream.push_back(length[15:8]);
        rx_stream.push_back(length[7:0]);
      end
      default: begin
        rx_stream.push_back({masked, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) rx_stream.push_back(length[8*i +: 8]);
      end
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--) rx_stream.push_back(key[8*i +: 8]);
    repeat (n_payload) rx_stream.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_word(input logic [7:0] b);
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    logic [7:0] hdr0;
    logic [3:0] op;
    logic       masked;
    len_form_t  form;
    int         len;
    int         k;
    int         burst;
    int         gap;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty frames, masked and unmasked, then reserved bits, reserved opcode and long forms.
    push_frame(8'h82, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0);
    push_frame(8'h08, 1'b1, LEN_SHORT, 64'd0, 32'hFF00A55A, 0);
    push_frame(8'h71, 1'b1, LEN_SHORT, 64'd2, 32'hFF00A55A, 2);
    push_frame(8'h8F, 1'b1, LEN_EXT16, 64'd0, 32'h12345678, 0);
    push_frame(8'h02, 1'b0, LEN_EXT64, 64'd1, 32'h0, 1);

    while (rx_stream.size() < 580) begin
      case ($urandom_range(0, 3))
        0: op = OP_BINARY;
        1: op = OP_CLOSE;
        default: op = 4'($urandom_range(0, 15));
      endcase
      hdr0 = {1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), op};
      masked = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin form = LEN_SHORT; len = $urandom_range(0, 12); end
        6: begin form = LEN_SHORT; len = $urandom_range(0, 125); end
        7: begin form = LEN_EXT16; len = $urandom_range(0, 40); end
        8: begin form = LEN_EXT64; len = $urandom_range(0, 40); end
        default: begin form = LEN_EXT16; len = $urandom_range(126, 300); end
      endcase
      push_frame(hdr0, masked, form, 64'(len), 32'($urandom), len);
    end

    // Hold the largest length last: the frame never ends.
    push_frame(8'h82, 1'b1, LEN_EXT64, {64{1'b1}}, 32'($urandom), 24);

    k = 0;
    while (k < rx_stream.size()) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && k < rx_stream.size()) begin
        send_word(rx_stream[k]);
        k++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

### files.f
rtl/wsfd_pkg.sv
rtl/wsfd_parse.sv
rtl/websocket_frame_deframer.sv
rtl/wsfd_checker.sv
sim/testbench.sv
